// ===== rtl/vcsp_pkg.sv =====
// Shared types and constants for the voxel chunk stream parser.
// Holds chunk tags, parse phase and result codes, and the queue entry type.
// No dependencies.
package vcsp_pkg;

	// Little-endian chunk tags as assembled from four bytes
	localparam logic [31:0] TAG_VOX  = 32'h2058_4F56;
	localparam logic [31:0] TAG_MAIN = 32'h4E49_414D;
	localparam logic [31:0] TAG_PACK = 32'h4B43_4150;
	localparam logic [31:0] TAG_SIZE = 32'h455A_4953;
	localparam logic [31:0] TAG_XYZI = 32'h495A_5958;
	localparam logic [31:0] TAG_RGBA = 32'h4142_4752;

	localparam int unsigned PALETTE_ENTRIES = 256;
	localparam logic [31:0] PALETTE_BYTES   = 32'(PALETTE_ENTRIES * 4);
	localparam logic [31:0] SIZE_BYTES      = 32'd12;
	localparam int unsigned PAL_CNT_W       = $clog2(PALETTE_ENTRIES + 1);

	// Default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		PH_MAGIC   = 4'd0,
		PH_VERSION = 4'd1,
		PH_TAG     = 4'd2,
		PH_CLEN    = 4'd3,
		PH_KIDS    = 4'd4,
		PH_SKIP    = 4'd5,
		PH_WIDTH   = 4'd6,
		PH_HEIGHT  = 4'd7,
		PH_DEPTH   = 4'd8,
		PH_COUNT   = 4'd9,
		PH_VOXEL   = 4'd10,
		PH_PALETTE = 4'd11,
		PH_DONE    = 4'd12,
		PH_ERROR   = 4'd13
	} phase_t;

	typedef enum logic [2:0] {
		CTX_MAIN   = 3'd0,
		CTX_FIRST  = 3'd1,
		CTX_SIZE   = 3'd2,
		CTX_XYZI   = 3'd3,
		CTX_SEARCH = 3'd4
	} ctx_t;

	typedef enum logic [2:0] {
		KIND_WIDTH   = 3'd0,
		KIND_HEIGHT  = 3'd1,
		KIND_DEPTH   = 3'd2,
		KIND_COUNT   = 3'd3,
		KIND_VOXEL   = 3'd4,
		KIND_PALETTE = 3'd5,
		KIND_ERROR   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ERR_BAD_MAGIC = 3'd0,
		ERR_MAIN_BAD  = 3'd1,
		ERR_SIZE_BAD  = 3'd2,
		ERR_NO_XYZI   = 3'd3,
		ERR_NO_RGBA   = 3'd4,
		ERR_PAL_SIZE  = 3'd5,
		ERR_TRUNCATED = 3'd6
	} err_t;

	// One parsed result
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [7:0]  palette_index;
		err_t        error_code;
		logic        finished;
	} result_t;

	// Queue entry: the results caused by one byte, at most a main result
	// followed by an end-of-stream error
	typedef struct packed {
		logic    has_main;
		result_t main;
		logic    has_eos;
		err_t    eos_code;
	} pair_t;

endpackage

// ===== rtl/vcsp_front.sv =====
// Front end of the voxel chunk stream parser: accepts bytes, assembles
// words and runs the chunk state machine, pushing an entry per byte with results.
// Depends on vcsp_pkg.
module vcsp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              end_of_stream,
	output logic              push,
	output vcsp_pkg::pair_t   push_data
);

	vcsp_pkg::phase_t                  phase_q, phase_d;
	vcsp_pkg::ctx_t                    ctx_q, ctx_d;
	logic [1:0]                        biw_q, biw_d;
	logic [31:0]                       word_q, word_d;
	logic [31:0]                       tag_q, tag_d;
	logic [31:0]                       clen_q, clen_d;
	logic [32:0]                       skip_q, skip_d;
	logic [31:0]                       vox_q, vox_d;
	logic [vcsp_pkg::PAL_CNT_W-1:0]    pal_q, pal_d;

	logic [31:0]                       ws;
	logic [vcsp_pkg::PAL_CNT_W-1:0]    pal_inc;
	logic                              searching;
	vcsp_pkg::pair_t                   pd;

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vcsp_pkg::PH_MAGIC;
			ctx_q   <= vcsp_pkg::CTX_MAIN;
			biw_q   <= '0;
			word_q  <= '0;
			tag_q   <= '0;
			clen_q  <= '0;
			skip_q  <= '0;
			vox_q   <= '0;
			pal_q   <= '0;
		end else begin
			phase_q <= phase_d;
			ctx_q   <= ctx_d;
			biw_q   <= biw_d;
			word_q  <= word_d;
			tag_q   <= tag_d;
			clen_q  <= clen_d;
			skip_q  <= skip_d;
			vox_q   <= vox_d;
			pal_q   <= pal_d;
		end
	end

	assign ws      = {data_byte, word_q[31:8]};
	assign pal_inc = pal_q + 1'b1;

	// Next state and results for the accepted byte
	always_comb begin
		phase_d   = phase_q;
		ctx_d     = ctx_q;
		biw_d     = biw_q;
		word_d    = word_q;
		tag_d     = tag_q;
		clen_d    = clen_q;
		skip_d    = skip_q;
		vox_d     = vox_q;
		pal_d     = pal_q;
		searching = 1'b0;
		pd        = '0;

		if (accept) begin
			if (phase_q == vcsp_pkg::PH_SKIP) begin
				// Drop one skipped byte
				skip_d = skip_q - 33'd1;
				if (skip_q == 33'd1) begin
					phase_d = vcsp_pkg::PH_TAG;
				end
			end else if (phase_q != vcsp_pkg::PH_DONE && phase_q != vcsp_pkg::PH_ERROR) begin
				word_d = ws;
				if (biw_q == 2'd3) begin
					biw_d = 2'd0;
					unique case (phase_q)
						vcsp_pkg::PH_MAGIC: begin
							if (ws != vcsp_pkg::TAG_VOX) begin
								phase_d = vcsp_pkg::PH_ERROR;
								pd.has_main = 1'b1;
								pd.main.kind = vcsp_pkg::KIND_ERROR;
								pd.main.error_code = vcsp_pkg::ERR_BAD_MAGIC;
							end else begin
								phase_d = vcsp_pkg::PH_VERSION;
							end
						end
						vcsp_pkg::PH_VERSION: begin
							ctx_d   = vcsp_pkg::CTX_MAIN;
							phase_d = vcsp_pkg::PH_TAG;
						end
						vcsp_pkg::PH_TAG: begin
							tag_d   = ws;
							phase_d = vcsp_pkg::PH_CLEN;
						end
						vcsp_pkg::PH_CLEN: begin
							clen_d  = ws;
							phase_d = vcsp_pkg::PH_KIDS;
						end
						vcsp_pkg::PH_KIDS: begin
							// Judge the chunk header
							unique case (ctx_q)
								vcsp_pkg::CTX_MAIN: begin
									if (tag_q != vcsp_pkg::TAG_MAIN || clen_q != 32'd0) begin
										phase_d = vcsp_pkg::PH_ERROR;
										pd.has_main = 1'b1;
										pd.main.kind = vcsp_pkg::KIND_ERROR;
										pd.main.error_code = vcsp_pkg::ERR_MAIN_BAD;
									end else begin
										ctx_d   = vcsp_pkg::CTX_FIRST;
										phase_d = vcsp_pkg::PH_TAG;
									end
								end
								vcsp_pkg::CTX_FIRST, vcsp_pkg::CTX_SIZE: begin
									if (ctx_q == vcsp_pkg::CTX_FIRST &&
											tag_q == vcsp_pkg::TAG_PACK) begin
										ctx_d  = vcsp_pkg::CTX_SIZE;
										skip_d = {1'b0, clen_q} + {1'b0, ws};
										phase_d = (clen_q == 32'd0 && ws == 32'd0) ?
											vcsp_pkg::PH_TAG : vcsp_pkg::PH_SKIP;
									end else if (tag_q != vcsp_pkg::TAG_SIZE ||
											clen_q != vcsp_pkg::SIZE_BYTES) begin
										phase_d = vcsp_pkg::PH_ERROR;
										pd.has_main = 1'b1;
										pd.main.kind = vcsp_pkg::KIND_ERROR;
										pd.main.error_code = vcsp_pkg::ERR_SIZE_BAD;
									end else begin
										phase_d = vcsp_pkg::PH_WIDTH;
									end
								end
								vcsp_pkg::CTX_XYZI: begin
									if (tag_q != vcsp_pkg::TAG_XYZI) begin
										phase_d = vcsp_pkg::PH_ERROR;
										pd.has_main = 1'b1;
										pd.main.kind = vcsp_pkg::KIND_ERROR;
										pd.main.error_code = vcsp_pkg::ERR_NO_XYZI;
									end else begin
										phase_d = vcsp_pkg::PH_COUNT;
									end
								end
								default: begin
									if (tag_q == vcsp_pkg::TAG_RGBA) begin
										if (clen_q != vcsp_pkg::PALETTE_BYTES) begin
											phase_d = vcsp_pkg::PH_ERROR;
											pd.has_main = 1'b1;
											pd.main.kind = vcsp_pkg::KIND_ERROR;
											pd.main.error_code = vcsp_pkg::ERR_PAL_SIZE;
										end else begin
											pal_d   = '0;
											phase_d = vcsp_pkg::PH_PALETTE;
										end
									end else begin
										skip_d = {1'b0, clen_q} + {1'b0, ws};
										phase_d = (clen_q == 32'd0 && ws == 32'd0) ?
											vcsp_pkg::PH_TAG : vcsp_pkg::PH_SKIP;
									end
								end
							endcase
						end
						vcsp_pkg::PH_WIDTH: begin
							phase_d = vcsp_pkg::PH_HEIGHT;
							pd.has_main = 1'b1;
							pd.main.kind = vcsp_pkg::KIND_WIDTH;
							pd.main.value = ws;
						end
						vcsp_pkg::PH_HEIGHT: begin
							phase_d = vcsp_pkg::PH_DEPTH;
							pd.has_main = 1'b1;
							pd.main.kind = vcsp_pkg::KIND_HEIGHT;
							pd.main.value = ws;
						end
						vcsp_pkg::PH_DEPTH: begin
							ctx_d   = vcsp_pkg::CTX_XYZI;
							phase_d = vcsp_pkg::PH_TAG;
							pd.has_main = 1'b1;
							pd.main.kind = vcsp_pkg::KIND_DEPTH;
							pd.main.value = ws;
						end
						vcsp_pkg::PH_COUNT: begin
							vox_d = ws;
							if (ws == 32'd0) begin
								ctx_d   = vcsp_pkg::CTX_SEARCH;
								phase_d = vcsp_pkg::PH_TAG;
							end else begin
								phase_d = vcsp_pkg::PH_VOXEL;
							end
							pd.has_main = 1'b1;
							pd.main.kind = vcsp_pkg::KIND_COUNT;
							pd.main.value = ws;
						end
						vcsp_pkg::PH_VOXEL: begin
							vox_d = vox_q - 32'd1;
							if (vox_q == 32'd1) begin
								ctx_d   = vcsp_pkg::CTX_SEARCH;
								phase_d = vcsp_pkg::PH_TAG;
							end
							pd.has_main = 1'b1;
							pd.main.kind = vcsp_pkg::KIND_VOXEL;
							pd.main.value = ws;
						end
						vcsp_pkg::PH_PALETTE: begin
							pal_d = pal_inc;
							pd.has_main = 1'b1;
							pd.main.kind = vcsp_pkg::KIND_PALETTE;
							pd.main.value = ws;
							pd.main.palette_index = pal_inc[7:0];
							if (pal_inc >= vcsp_pkg::PAL_CNT_W'(vcsp_pkg::PALETTE_ENTRIES)) begin
								pd.main.finished = 1'b1;
								phase_d = vcsp_pkg::PH_DONE;
							end
						end
						default: begin
						end
					endcase
				end else begin
					biw_d = biw_q + 2'd1;
				end
			end

			// Close the stream: flag an unfinished parse, then return to the header
			if (end_of_stream) begin
				if (phase_d != vcsp_pkg::PH_DONE && phase_d != vcsp_pkg::PH_ERROR) begin
					searching = ctx_d == vcsp_pkg::CTX_SEARCH &&
						(phase_d == vcsp_pkg::PH_TAG || phase_d == vcsp_pkg::PH_CLEN ||
						 phase_d == vcsp_pkg::PH_KIDS || phase_d == vcsp_pkg::PH_SKIP);
					pd.has_eos  = 1'b1;
					pd.eos_code = searching ? vcsp_pkg::ERR_NO_RGBA : vcsp_pkg::ERR_TRUNCATED;
				end
				phase_d = vcsp_pkg::PH_MAGIC;
				ctx_d   = vcsp_pkg::CTX_MAIN;
				biw_d   = '0;
				word_d  = '0;
				tag_d   = '0;
				clen_d  = '0;
				skip_d  = '0;
				vox_d   = '0;
				pal_d   = '0;
			end
		end
	end

	assign push      = pd.has_main | pd.has_eos;
	assign push_data = pd;

endmodule

// ===== rtl/vcsp_queue.sv =====
// Short queue of per-byte result entries between front and back.
// Register-file storage with read and write pointers and a fill count.
// Depends on vcsp_pkg.
module vcsp_queue #(
	parameter int unsigned DEPTH = vcsp_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vcsp_pkg::pair_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output vcsp_pkg::pair_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	vcsp_pkg::pair_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full       = cnt_q == CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	// Write the entry store
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/vcsp_back.sv =====
// Back end of the voxel chunk stream parser: unpacks queue entries into
// single result transactions held in an output register.
// Depends on vcsp_pkg.
module vcsp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  vcsp_pkg::pair_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      kind,
	output logic [31:0]     value,
	output logic [7:0]      palette_index,
	output logic [2:0]      error_code,
	output logic            finished,
	output logic            last_of_run
);

	logic             valid_q;
	logic             half_q;
	vcsp_pkg::result_t res_q;
	logic             last_q;
	logic             load;
	logic             take_main;
	vcsp_pkg::result_t res_d;
	logic             last_d;

	assign load      = head_valid & (~valid_q | out_ready);
	assign take_main = head.has_main & ~half_q;
	assign pop       = load & (~take_main | ~head.has_eos);

	// Pick the next result of the head entry
	always_comb begin
		res_d = '0;
		if (take_main) begin
			res_d  = head.main;
			last_d = ~head.has_eos;
		end else begin
			res_d.kind       = vcsp_pkg::KIND_ERROR;
			res_d.error_code = head.eos_code;
			last_d           = 1'b1;
		end
	end

	// Hold the output transaction and track which half of the entry is next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				half_q  <= take_main & head.has_eos;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= res_d;
			last_q <= last_d;
		end
	end

	assign out_valid     = valid_q;
	assign kind          = res_q.kind;
	assign value         = res_q.value;
	assign palette_index = res_q.palette_index;
	assign error_code    = res_q.error_code;
	assign finished      = res_q.finished;
	assign last_of_run   = last_q;

endmodule

// ===== rtl/voxel_chunk_stream_parser.sv =====
// Top level of the voxel chunk stream parser: front end, entry queue, back end.
// Depends on vcsp_pkg, vcsp_front, vcsp_queue and vcsp_back.
//
// The parser takes one file byte per cycle while its queue has room and
// emits width, height, depth, voxel count, voxel words, palette entries
// and errors as result transactions, one per cycle while out_ready is high.
// A byte that causes two results (a word result followed by the
// end-of-stream error) yields two transactions; the queue of QUEUE_DEPTH
// entries between the byte parser and the output register absorbs those
// and any output stalls. With the queue empty, a byte's first result is
// written to the queue and then loaded into the output register. After an
// error or a completed palette, bytes are consumed silently until the
// end-of-stream byte, which returns the parser to expecting the file magic.
module voxel_chunk_stream_parser #(
	parameter int unsigned QUEUE_DEPTH = vcsp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] value,
	output logic [7:0]  palette_index,
	output logic [2:0]  error_code,
	output logic        finished,
	output logic        last_of_run
);

	logic            accept;
	logic            push;
	logic            full;
	logic            pop;
	logic            head_valid;
	vcsp_pkg::pair_t push_data;
	vcsp_pkg::pair_t head;

	assign in_ready = ~full;
	assign accept   = in_valid & ~full;

	vcsp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.push          (push),
		.push_data     (push_data)
	);

	vcsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	vcsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.value         (value),
		.palette_index (palette_index),
		.error_code    (error_code),
		.finished      (finished),
		.last_of_run   (last_of_run)
	);

endmodule
